// ----- sv/bve_pkg.sv -----
`default_nettype none

package bve_pkg;

	localparam int DATA_W    = 32;
	localparam int WIN_DEPTH = 10;
	localparam int WIN_IDX_W = $clog2(WIN_DEPTH);
	localparam int SUM_W     = DATA_W + WIN_IDX_W;

	// split divide of the window sum: high part, then remainder joined to low part
	localparam int LO_W     = 16;
	localparam int HI_W     = SUM_W - LO_W;
	localparam int Y_W      = WIN_IDX_W + LO_W;
	localparam int HI_SH    = HI_W + WIN_IDX_W;
	localparam int Y_SH     = Y_W + WIN_IDX_W;
	localparam int HI_MUL_W = HI_W + 1;
	localparam int Y_MUL_W  = Y_W + 1;

	localparam logic [HI_MUL_W-1:0] HI_MUL = HI_MUL_W'(
		((64'd1 << HI_SH) + 64'(WIN_DEPTH) - 64'd1) / 64'(WIN_DEPTH));
	localparam logic [Y_MUL_W-1:0] Y_MUL = Y_MUL_W'(
		((64'd1 << Y_SH) + 64'(WIN_DEPTH) - 64'd1) / 64'(WIN_DEPTH));

	// floor(x / 5) for any 32-bit unsigned x
	localparam logic [31:0] DIV5_MUL = 32'hCCCC_CCCD;
	localparam int          DIV5_SH  = 34;

	typedef logic signed [DATA_W-1:0] sample_t;
	typedef logic signed [SUM_W-1:0]  sum_t;

	typedef struct packed {
		sample_t altitude;
		sample_t velocity;
	} echo_t;

endpackage

`default_nettype wire

// ----- sv/bve_cell.sv -----
`default_nettype none

module bve_cell (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             shift,
	input  bve_pkg::sample_t d,
	output bve_pkg::sample_t q
);
	import bve_pkg::*;

	sample_t entry_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			entry_q <= '0;
		end else if (shift) begin
			entry_q <= d;
		end
	end

	assign q = entry_q;

endmodule

`default_nettype wire

// ----- sv/bve_avg_div.sv -----
`default_nettype none

module bve_avg_div (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             in_valid,
	output logic             in_ready,
	input  bve_pkg::sum_t    sum,
	input  bve_pkg::echo_t   echo_in,
	output logic             out_valid,
	input  logic             out_ready,
	output bve_pkg::sample_t average,
	output bve_pkg::echo_t   echo_out
);
	import bve_pkg::*;

	localparam int HP_W = HI_W + HI_MUL_W;
	localparam int YP_W = Y_W + Y_MUL_W;

	logic v_s1, v_s2, v_s3, v_s4, out_valid_q;
	logic en_s1, en_s2, en_s3, en_s4, en_out;

	logic              neg_s1, neg_s2, neg_s3, neg_s4;
	logic [SUM_W-1:0]  mag_s1;
	logic [HI_W-1:0]   hi_s2, qh_s2, qh_s3, qh_s4;
	logic [LO_W-1:0]   lo_s2, qy_s4;
	logic [Y_W-1:0]    y_s3;
	echo_t             echo_s1, echo_s2, echo_s3, echo_s4, echo_q;
	sample_t           average_q;

	logic [HI_W-1:0]   hi;
	logic [HP_W-1:0]   prod_hi;
	logic [HI_W-1:0]   qd;
	logic [HI_W-1:0]   rh;
	logic [YP_W-1:0]   prod_y;
	logic [SUM_W-1:0]  quo;
	logic [SUM_W-1:0]  quo_signed;

	assign en_out   = !out_valid_q || out_ready;
	assign en_s4    = !v_s4 || en_out;
	assign en_s3    = !v_s3 || en_s4;
	assign en_s2    = !v_s2 || en_s3;
	assign en_s1    = !v_s1 || en_s2;
	assign in_ready = en_s1;

	assign hi         = mag_s1[SUM_W-1:LO_W];
	assign prod_hi    = HP_W'(hi) * HP_W'(HI_MUL);
	assign qd         = qh_s2 * HI_W'(WIN_DEPTH);
	assign rh         = hi_s2 - qd;
	assign prod_y     = YP_W'(y_s3) * YP_W'(Y_MUL);
	assign quo        = {qh_s4, qy_s4};
	assign quo_signed = neg_s4 ? (~quo + SUM_W'(1)) : quo;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1        <= 1'b0;
			v_s2        <= 1'b0;
			v_s3        <= 1'b0;
			v_s4        <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (en_s1) begin
				v_s1 <= in_valid;
			end
			if (en_s2) begin
				v_s2 <= v_s1;
			end
			if (en_s3) begin
				v_s3 <= v_s2;
			end
			if (en_s4) begin
				v_s4 <= v_s3;
			end
			if (en_out) begin
				out_valid_q <= v_s4;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (en_s1) begin
			neg_s1  <= sum[SUM_W-1];
			mag_s1  <= sum[SUM_W-1] ? (~sum + SUM_W'(1)) : sum;
			echo_s1 <= echo_in;
		end
		if (en_s2) begin
			neg_s2  <= neg_s1;
			hi_s2   <= hi;
			lo_s2   <= mag_s1[LO_W-1:0];
			qh_s2   <= HI_W'(prod_hi >> HI_SH);
			echo_s2 <= echo_s1;
		end
		if (en_s3) begin
			neg_s3  <= neg_s2;
			qh_s3   <= qh_s2;
			y_s3    <= {rh[WIN_IDX_W-1:0], lo_s2};
			echo_s3 <= echo_s2;
		end
		if (en_s4) begin
			neg_s4  <= neg_s3;
			qh_s4   <= qh_s3;
			qy_s4   <= LO_W'(prod_y >> Y_SH);
			echo_s4 <= echo_s3;
		end
		if (en_out) begin
			average_q <= sample_t'(quo_signed[DATA_W-1:0]);
			echo_q    <= echo_s4;
		end
	end

	assign out_valid = out_valid_q;
	assign average   = average_q;
	assign echo_out  = echo_q;

endmodule

`default_nettype wire

// ----- sv/baro_velocity_estimator.sv -----
`default_nettype none

// Barometric vertical-velocity estimator. Each item is one altitude sample (signed
// Q16.16 m); each result carries the echoed altitude, the smoothed velocity
// (0.2 * old + 0.8 * finite difference over 0.01 s, saturated, held while the previous
// sample is zero) and the truncated mean of the last WIN_DEPTH velocities, all signed
// Q16.16. One item is taken every clock while out_ready does not stall the chain.
// The throughput is set by the velocity update, which closes its divide-by-five
// (a 32x32 reciprocal multiply) and saturation combinationally. The window is a
// shift chain of cells with a running sum; the mean goes through a four-stage
// reciprocal divider and an output register; a waiting result backs up into the input.

module baro_velocity_estimator (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             in_valid,
	output logic             in_ready,
	input  bve_pkg::sample_t altitude_sample,
	output logic             out_valid,
	input  logic             out_ready,
	output bve_pkg::sample_t altitude_out,
	output bve_pkg::sample_t velocity,
	output bve_pkg::sample_t mean_velocity
);
	import bve_pkg::*;

	localparam int DIFF_W = DATA_W + 1;
	localparam int QV5_W  = DATA_W + 3;
	localparam int T_W    = DATA_W + 10;
	localparam int QX_W   = 64 - DIV5_SH;

	sample_t prev_q, vel_q;
	sum_t    sum_q;

	logic    v_s1;
	echo_t   echo_s1;
	sum_t    sum_s1;
	logic    en_s1;
	logic    accept;
	logic    div_ready;
	echo_t   echo_out;

	sample_t tap [WIN_DEPTH+1];

	logic              v_neg;
	logic [DATA_W:0]   x_wide;
	logic [63:0]       x_prod;
	logic [QX_W-1:0]   qx;
	logic [DATA_W-1:0] qv_mag;
	sample_t           qv;
	logic [QV5_W-1:0]  five_qv;
	logic              rv_nz;
	logic [DIFF_W-1:0] diff;
	logic [T_W-1:0]    d80;
	logic [T_W-1:0]    t;
	logic [T_W-1:0]    vn;
	logic              sat_hi, sat_lo;
	sample_t           vsat;
	sample_t           vel_next;
	sum_t              sum_next;

	assign accept   = in_valid && in_ready;
	assign en_s1    = !v_s1 || div_ready;
	assign in_ready = en_s1;

	// floor(v / 5) via magnitude; negative v uses floor((4 - v) / 5)
	assign v_neg   = vel_q[DATA_W-1];
	assign x_wide  = v_neg ? ((DIFF_W)'(4) - {vel_q[DATA_W-1], vel_q})
		: {vel_q[DATA_W-1], vel_q};
	assign x_prod  = 64'(x_wide[DATA_W-1:0]) * 64'(DIV5_MUL);
	assign qx      = x_prod[63:DIV5_SH];
	assign qv_mag  = DATA_W'(qx);
	assign qv      = v_neg ? -sample_t'(qv_mag) : sample_t'(qv_mag);
	assign five_qv = (QV5_W'(qv) << 2) + QV5_W'(qv);
	assign rv_nz   = five_qv != QV5_W'(vel_q);

	// trunc((v + 400*d) / 5) = floor(v/5) + 80*d, plus one when negative and inexact
	assign diff = DIFF_W'(altitude_sample) - DIFF_W'(prev_q);
	assign d80  = (T_W'(signed'(diff)) << 6) + (T_W'(signed'(diff)) << 4);
	assign t    = d80 + T_W'(qv);
	assign vn   = t + ((t[T_W-1] && rv_nz) ? T_W'(1) : T_W'(0));

	assign sat_hi = !vn[T_W-1] && (vn[T_W-1:DATA_W-1] != '0);
	assign sat_lo = vn[T_W-1] && (vn[T_W-1:DATA_W-1] != '1);
	always_comb begin
		if (sat_hi) begin
			vsat = sample_t'({1'b0, {(DATA_W-1){1'b1}}});
		end else if (sat_lo) begin
			vsat = sample_t'({1'b1, {(DATA_W-1){1'b0}}});
		end else begin
			vsat = sample_t'(vn[DATA_W-1:0]);
		end
	end

	assign vel_next = (prev_q != '0) ? vsat : vel_q;
	assign sum_next = sum_q - SUM_W'(tap[WIN_DEPTH]) + SUM_W'(vel_next);

	assign tap[0] = vel_next;

	for (genvar k = 0; k < WIN_DEPTH; k++) begin : g_win
		bve_cell u_cell (
			.clk    (clk),
			.arst_n (arst_n),
			.shift  (accept),
			.d      (tap[k]),
			.q      (tap[k+1])
		);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			prev_q <= '0;
			vel_q  <= '0;
			sum_q  <= '0;
			v_s1   <= 1'b0;
		end else begin
			if (accept) begin
				prev_q <= altitude_sample;
				vel_q  <= vel_next;
				sum_q  <= sum_next;
			end
			if (en_s1) begin
				v_s1 <= in_valid;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (en_s1) begin
			echo_s1.altitude <= altitude_sample;
			echo_s1.velocity <= vel_next;
			sum_s1           <= sum_next;
		end
	end

	bve_avg_div u_avg_div (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (v_s1),
		.in_ready  (div_ready),
		.sum       (sum_s1),
		.echo_in   (echo_s1),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.average   (mean_velocity),
		.echo_out  (echo_out)
	);

	assign altitude_out = echo_out.altitude;
	assign velocity     = echo_out.velocity;

	a_hold_vel_on_zero_prev: assert property (@(posedge clk) disable iff (!arst_n)
		(accept && prev_q == '0) |=> $stable(vel_q))
		else $error("velocity changed after a zero previous sample");

	a_prev_tracks_sample: assert property (@(posedge clk) disable iff (!arst_n)
		accept |=> (prev_q == $past(altitude_sample)))
		else $error("previous sample not taken from accepted item");

	a_s1_holds_on_stall: assert property (@(posedge clk) disable iff (!arst_n)
		(v_s1 && !div_ready) |=> (v_s1 && $stable(sum_s1)))
		else $error("first stage lost its item while the divider stalled");

endmodule

`default_nettype wire
